// ----- hdl/stjs_pkg.sv -----
// Shared types and codes for the sorted table jump search block.
// No dependencies.
package stjs_pkg;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_SORT   = 2'd2,
      OP_SEARCH = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FOUND = 2'd1,
      ST_MISS  = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   localparam int KEY_W = 16;
   localparam int PAY_W = 50;
   localparam int POS_W = 10;

   typedef struct packed {
      op_type            operation;
      logic [KEY_W-1:0]  key;
      logic [PAY_W-1:0]  payload;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [POS_W-1:0]  position;
      logic [KEY_W-1:0]  found_key;
      logic [PAY_W-1:0]  found_payload;
   } rsp_type;

   typedef enum logic [3:0] {
      EX_IDLE,
      EX_SQRT,
      EX_SORT_RD_I,
      EX_SORT_RD_J,
      EX_SORT_CMP,
      EX_SORT_WR_J,
      EX_FWD_RD,
      EX_FWD_CHK,
      EX_BACK_RD,
      EX_BACK_CHK,
      EX_HIT_RD,
      EX_HIT_CHK,
      EX_EMIT
   } ex_state_type;

endpackage

// ----- hdl/stjs_if.sv -----
// Valid/ready channel interfaces for request and response.
// Depends on stjs_pkg.
interface stjs_req_if import stjs_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface stjs_rsp_if import stjs_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/stjs_queue.sv -----
// Two-entry request queue between the front part and the executor.
// Depends on stjs_pkg.
module stjs_queue import stjs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output req_type out_data
);
   req_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid & in_ready;
   assign pop  = out_valid & out_ready;

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_data;
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count overflow");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> !pop) else $error("pop from empty queue");
   a_push: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> !push) else $error("push into full queue");
endmodule

// ----- hdl/stjs_exec.sv -----
// Executor: table memories, sort, jump search and the output register.
// Depends on stjs_pkg.
module stjs_exec import stjs_pkg::*; #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int SW = CW;

   logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
   logic [PAY_W-1:0] pay_mem [TABLE_DEPTH];

   ex_state_type st_ff, st_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   req_type       req_ff;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, cur_ff, cur_in;
   logic [SW-1:0] step_ff, step_in;
   logic [2*SW+1:0] sq_ff, sq_in;  // (step+1)^2
   logic [KEY_W-1:0] ki_ff, ki_in;
   logic [PAY_W-1:0] pi_ff, pi_in;
   logic [KEY_W-1:0] rk_ff;
   logic [PAY_W-1:0] rp_ff;
   logic             ov_ff, ov_in;
   rsp_type          od_ff, od_in;

   // memory port control
   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [KEY_W-1:0] wr_key;
   logic [PAY_W-1:0] wr_pay;

   logic [CW-1:0] last;
   logic [CW:0]   nxt;

   // key i is captured in RD_J from the read issued in RD_I
   logic fresh_ff;
   logic capture_i;

   assign last     = cnt_ff - 1'b1;
   assign nxt      = {1'b0, cur_ff} + {1'b0, step_ff};
   assign in_ready = (st_ff == EX_IDLE) & ~ov_ff;
   assign out_valid = ov_ff;
   assign out_data  = od_ff;
   assign capture_i = (st_ff == EX_SORT_RD_J) && (j_ff == i_ff + 1'b1) && fresh_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         pay_mem[wr_addr] <= wr_pay;
      end
      if (rd_en) begin
         rk_ff <= key_mem[rd_addr];
         rp_ff <= pay_mem[rd_addr];
      end
   end

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         EX_IDLE: begin
            if (in_valid & in_ready) begin
               unique case (in_data.operation)
                  OP_CLEAR, OP_APPEND: st_in = EX_EMIT;
                  OP_SORT:   st_in = (cnt_ff > 1) ? EX_SORT_RD_I : EX_EMIT;
                  OP_SEARCH: st_in = (cnt_ff != 0) ? EX_SQRT : EX_EMIT;
               endcase
            end
         end
         EX_SQRT:      if (sq_ff > {{(SW+2){1'b0}}, cnt_ff}) st_in = EX_FWD_RD;
         EX_SORT_RD_I: st_in = EX_SORT_RD_J;
         EX_SORT_RD_J: st_in = EX_SORT_CMP;
         EX_SORT_CMP:  st_in = (ki_ff > rk_ff) ? EX_SORT_WR_J : EX_SORT_RD_J;
         EX_SORT_WR_J: st_in = EX_SORT_RD_J;
         EX_FWD_RD:    st_in = EX_FWD_CHK;
         EX_FWD_CHK:   st_in = EX_FWD_RD;
         EX_BACK_RD:   st_in = EX_BACK_CHK;
         EX_BACK_CHK:  st_in = EX_BACK_RD;
         EX_HIT_RD:    st_in = EX_HIT_CHK;
         EX_HIT_CHK:   st_in = EX_EMIT;
         EX_EMIT:      st_in = EX_IDLE;
         default:      st_in = EX_IDLE;
      endcase
      // data-dependent exits
      if (st_ff == EX_SORT_CMP && !(ki_ff > rk_ff) && j_ff == last) begin
         st_in = (i_ff + 2'd2 >= cnt_ff) ? EX_EMIT : EX_SORT_RD_I;
      end
      if (st_ff == EX_SORT_WR_J && j_ff == last) begin
         st_in = (i_ff + 2'd2 >= cnt_ff) ? EX_EMIT : EX_SORT_RD_I;
      end
      if (st_ff == EX_FWD_CHK) begin
         if (rk_ff > req_ff.key) st_in = EX_BACK_RD;
         else if (rk_ff == req_ff.key || cur_ff == last) st_in = EX_EMIT;
      end
      if (st_ff == EX_BACK_CHK) begin
         if (!(rk_ff > req_ff.key)) st_in = EX_EMIT;
         else if (cur_ff == 0) st_in = EX_EMIT;
      end
   end

   // datapath and outputs
   always_comb begin
      cnt_in = cnt_ff; i_in = i_ff; j_in = j_ff; cur_in = cur_ff;
      step_in = step_ff; sq_in = sq_ff; ki_in = ki_ff; pi_in = pi_ff;
      ov_in = ov_ff; od_in = od_ff;
      rd_en = 1'b0; rd_addr = '0; wr_en = 1'b0; wr_addr = '0;
      wr_key = '0; wr_pay = '0;
      if (ov_ff & out_ready) ov_in = 1'b0;
      unique case (st_ff)
         EX_IDLE: begin
            i_in = '0; cur_in = '0; step_in = '0; sq_in = (2*SW+2)'(1);
            if (in_valid & in_ready) begin
               od_in = '0;
               od_in.status = ST_DONE;
               unique case (in_data.operation)
                  OP_CLEAR: cnt_in = '0;
                  OP_APPEND: begin
                     if (cnt_ff >= CW'(TABLE_DEPTH)) od_in.status = ST_FULL;
                     else begin
                        wr_en = 1'b1; wr_addr = cnt_ff[AW-1:0];
                        wr_key = in_data.key; wr_pay = in_data.payload;
                        cnt_in = cnt_ff + 1'b1;
                     end
                  end
                  OP_SORT: ;
                  OP_SEARCH: od_in.status = ST_MISS;
               endcase
            end
         end
         EX_SQRT: begin
            if (!(sq_ff > {{(SW+2){1'b0}}, cnt_ff})) begin
               step_in = step_ff + 1'b1;
               // (s+2)^2 = (s+1)^2 + 2s + 3
               sq_in = sq_ff + (2*SW+2)'({step_ff, 1'b0}) + (2*SW+2)'(3);
            end
         end
         EX_SORT_RD_I: begin
            rd_en = 1'b1; rd_addr = i_ff[AW-1:0];
            j_in = i_ff + 1'b1;
         end
         EX_SORT_RD_J: begin
            rd_en = 1'b1; rd_addr = j_ff[AW-1:0];
         end
         EX_SORT_CMP: begin
            if (ki_ff > rk_ff) begin
               // swap: i takes j now, j gets old i next cycle
               wr_en = 1'b1; wr_addr = i_ff[AW-1:0];
               wr_key = rk_ff; wr_pay = rp_ff;
            end else begin
               if (j_ff == last) i_in = i_ff + 1'b1;
               else j_in = j_ff + 1'b1;
            end
         end
         EX_SORT_WR_J: begin
            wr_en = 1'b1; wr_addr = j_ff[AW-1:0];
            wr_key = ki_ff; wr_pay = pi_ff;
            ki_in = rk_ff; pi_in = rp_ff;  // rk still holds old j, now the entry at i
            if (j_ff == last) i_in = i_ff + 1'b1;
            else j_in = j_ff + 1'b1;
         end
         EX_FWD_RD: begin
            rd_en = 1'b1; rd_addr = cur_ff[AW-1:0];
         end
         EX_FWD_CHK: begin
            if (!(rk_ff > req_ff.key) && rk_ff != req_ff.key && cur_ff != last)
               cur_in = (nxt >= {1'b0, cnt_ff}) ? last : nxt[CW-1:0];
            if (rk_ff == req_ff.key) begin
               od_in.status = ST_FOUND; od_in.position = POS_W'(cur_ff);
               od_in.found_key = rk_ff; od_in.found_payload = rp_ff;
            end
         end
         EX_BACK_RD: begin
            rd_en = 1'b1; rd_addr = cur_ff[AW-1:0];
         end
         EX_BACK_CHK: begin
            if (rk_ff > req_ff.key) begin
               if (cur_ff != 0) cur_in = cur_ff - 1'b1;
            end else if (rk_ff == req_ff.key) begin
               od_in.status = ST_FOUND; od_in.position = POS_W'(cur_ff);
               od_in.found_key = rk_ff; od_in.found_payload = rp_ff;
            end
         end
         EX_HIT_RD, EX_HIT_CHK: ;
         EX_EMIT: ov_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= EX_IDLE; cnt_ff <= '0; ov_ff <= 1'b0; fresh_ff <= 1'b0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; ov_ff <= ov_in;
         fresh_ff <= (st_ff == EX_SORT_RD_I);
      end
      if (st_ff == EX_IDLE && in_valid && in_ready) req_ff <= in_data;
      i_ff <= i_in; j_ff <= j_in; cur_ff <= cur_in;
      step_ff <= step_in; sq_ff <= sq_in; od_ff <= od_in;
      if (capture_i) begin
         ki_ff <= rk_ff; pi_ff <= rp_ff;
      end else begin
         ki_ff <= ki_in; pi_ff <= pi_in;
      end
   end

   a_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != EX_IDLE) |-> !in_ready) else $error("accept while busy");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(TABLE_DEPTH)) else $error("entry count beyond depth");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && !out_ready) |=> ov_ff && $stable(od_ff)) else $error("response lost");
   a_emit: assert property (@(posedge clock) disable iff (reset)
      (st_ff == EX_EMIT) |-> !ov_ff) else $error("response overwritten");
endmodule

// ----- hdl/sorted_table_jump_search_top.sv -----
// Top level of the sorted table jump search block.
// Depends on stjs_pkg, stjs_if, stjs_queue and stjs_exec.
//
// Requests (operation, key, payload) enter on req_ch; one response
// (status, position, found_key, found_payload) leaves on rsp_ch per
// request, in order. A two-entry queue takes requests while the executor
// works. Clear and append go straight to the emit state; a search
// first finds the step floor(sqrt(count)), then reads one table
// entry at a time (single read port, registered read): up to about
// sqrt(count) entries forward and step+1 backward. Sort reads each
// row once, then reads and compares every later row against it, with
// an extra write per swap; count*(count-1)/2 compares in all. The
// response register holds until rsp_ch.ready; the executor
// waits for it to empty before the next request, and once the queue is
// full req_ch.ready drops. Reset empties the table count, the queue and
// the response register; table memories are not cleared.
module sorted_table_jump_search_top import stjs_pkg::*; #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic clock,
   input  logic reset,
   stjs_req_if.sink   req_ch,
   stjs_rsp_if.source rsp_ch
);
   logic    q_valid, q_ready;
   req_type q_data;

   stjs_queue u_queue (
      .clock, .reset,
      .in_valid(req_ch.valid), .in_ready(req_ch.ready), .in_data(req_ch.data),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   stjs_exec #(.TABLE_DEPTH(TABLE_DEPTH)) u_exec (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
      .out_valid(rsp_ch.valid), .out_ready(rsp_ch.ready), .out_data(rsp_ch.data)
   );
endmodule
